// ===== rtl/core/first_fit_cell_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// First-fit cell allocator assertion macros
// Shared property wrappers for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_CELL_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_CELL_ALLOCATOR_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset
`define FFCA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included
`define FFCA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ffca_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit cell allocator package
// Pool geometry, mark store layout and result codes.
// ----------------------------------------------------------------------------
package ffca_pkg;

    // Pool geometry (absolute cell addresses)
    localparam int POOL_BASE  = 1024;
    localparam int POOL_LIMIT = 8192;
    localparam int POOL_CELLS = POOL_LIMIT - POOL_BASE;

    // Field widths
    localparam int ADDR_W  = 13;
    localparam int CELL_W  = 13;
    localparam int TDATA_W = 32;

    // Mark store layout: one bit per cell, packed into words
    localparam int WORD_W         = 32;
    localparam int BIT_W          = 5;
    localparam int WORDS          = POOL_CELLS / WORD_W;
    localparam int WORD_IDX_W     = CELL_W - BIT_W;
    localparam int BYTE_W         = 8;
    localparam int POS_W          = 3;
    localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
    localparam int BYTE_IDX_W     = BIT_W - POS_W;

    // Request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

endpackage

// ===== rtl/core/ffca_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ffca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 224,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; hold data between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/first_fit_cell_allocator_core.sv =====
// Free: a read and a write of each mark word touched (up to 224 words).
// Allocate: a fetch and an examine of each word scanned, plus up to 4 byte steps per mixed word,
//   plus a read and a write of each word marked; the mark RAM has one read port and one write port.
// One transaction at a time; the next is taken once the result is registered.
// Reset (aresetn low, synchronous): clearing pass over all 224 words of the mark RAM, s_tready low.
// ----------------------------------------------------------------------------
// First-fit cell allocator core
// Keeps a used/free mark per pool cell and serves allocate and free requests
// by a sequenced word scan and read-modify-write of the mark RAM.
// ----------------------------------------------------------------------------
`include "first_fit_cell_allocator_core_assert.svh"

module first_fit_cell_allocator_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ffca_pkg::TDATA_W-1:0] s_tdata,  // [12:0] start_address, [25:13] cell_count
    input  logic                         s_tuser,  // [0] opcode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ffca_pkg::TDATA_W-1:0] m_tdata,  // [12:0] run_address, [25:13] run_length
    output logic                         m_tuser   // [0] status
);

    import ffca_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b0_0000_0001,
        S_IDLE   = 9'b0_0000_0010,
        S_PREP   = 9'b0_0000_0100,
        S_FETCH  = 9'b0_0000_1000,
        S_EXAM   = 9'b0_0001_0000,
        S_BYTE   = 9'b0_0010_0000,
        S_UPD_RD = 9'b0_0100_0000,
        S_UPD_WR = 9'b0_1000_0000,
        S_RESP   = 9'b1_0000_0000
    } state_t;

    state_t                  state_reg,     state_next;
    logic                    op_reg,        op_next;
    logic [ADDR_W-1:0]       start_reg,     start_next;
    logic [CELL_W-1:0]       count_reg,     count_next;
    logic [CELL_W-1:0]       run_reg,       run_next;
    logic [WORD_IDX_W-1:0]   word_idx_reg,  word_idx_next;
    logic [BYTE_IDX_W-1:0]   byte_idx_reg,  byte_idx_next;
    logic [CELL_W-1:0]       lo_cell_reg,   lo_cell_next;
    logic [CELL_W-1:0]       hi_cell_reg,   hi_cell_next;
    logic                    set_reg,       set_next;
    logic [ADDR_W-1:0]       res_addr_reg,  res_addr_next;
    logic [CELL_W-1:0]       res_len_reg,   res_len_next;
    logic                    res_fail_reg,  res_fail_next;
    logic                    m_tvalid_reg,  m_tvalid_next;
    logic [ADDR_W-1:0]       m_addr_reg,    m_addr_next;
    logic [CELL_W-1:0]       m_len_reg,     m_len_next;
    logic                    m_status_reg,  m_status_next;

    // Mark RAM port signals
    logic                    ram_wr_en;
    logic [WORD_W-1:0]       ram_wr_data;
    logic                    ram_rd_en;
    logic [WORD_W-1:0]       ram_rd_data;
    logic [BYTES_PER_WORD-1:0][BYTE_W-1:0] ram_bytes;

    // Free range preparation
    logic [CELL_W:0]         free_sum;
    logic                    free_valid;
    logic [ADDR_W-1:0]       free_lo_abs;
    logic [ADDR_W-1:0]       free_hi_abs;

    // Scan unit
    logic [CELL_W:0]         word_run_sum;
    logic                    word_fit;
    logic [CELL_W-1:0]       word_gap;
    logic [CELL_W-1:0]       byte_run;
    logic                    byte_hit;
    logic [POS_W-1:0]        byte_pos;
    logic [CELL_W-1:0]       hit_end;
    logic [CELL_W-1:0]       hit_lo;

    // Update unit
    logic [BIT_W-1:0]        lo_bit;
    logic [BIT_W-1:0]        hi_bit;
    logic [WORD_W-1:0]       upd_mask;

    // ------------------------------------------------------------------------
    // Mark RAM: one bit per pool cell, addressed by word
    // ------------------------------------------------------------------------
    ffca_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_mark_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (word_idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (word_idx_reg),
        .rd_data (ram_rd_data)
    );

    assign ram_bytes = ram_rd_data;

    // Clip the freed range to the pool
    always_comb begin
        free_sum    = {1'b0, start_reg} + {1'b0, count_reg};
        free_valid  = (count_reg != '0) && (free_sum > (CELL_W+1)'(POOL_BASE));
        free_lo_abs = (start_reg < ADDR_W'(POOL_BASE)) ? ADDR_W'(POOL_BASE) : start_reg;
        if (free_sum > (CELL_W+1)'(POOL_LIMIT)) begin
            free_hi_abs = ADDR_W'(POOL_LIMIT - 1);
        end else begin
            free_hi_abs = free_sum[ADDR_W-1:0] - 1'b1;
        end
    end

    // Whole-word fast path for a word with every cell free
    always_comb begin
        word_run_sum = {1'b0, run_reg} + (CELL_W+1)'(WORD_W);
        word_fit     = word_run_sum >= {1'b0, count_reg};
        word_gap     = count_reg - run_reg - 1'b1;
    end

    // Byte step: extend the free run bit by bit, stop at the first fit
    always_comb begin
        byte_run = run_reg;
        byte_hit = 1'b0;
        byte_pos = '0;
        for (int j = 0; j < BYTE_W; j++) begin
            if (!byte_hit) begin
                if (ram_bytes[byte_idx_reg][j]) begin
                    byte_run = '0;
                end else begin
                    byte_run = byte_run + 1'b1;
                    if (byte_run == count_reg) begin
                        byte_hit = 1'b1;
                        byte_pos = POS_W'(j);
                    end
                end
            end
        end
    end

    // Last cell of the fitting run and its first cell
    always_comb begin
        if (state_reg == S_BYTE) begin
            hit_end = {word_idx_reg, byte_idx_reg, byte_pos};
        end else begin
            hit_end = {word_idx_reg, word_gap[BIT_W-1:0]};
        end
        hit_lo = hit_end - count_reg + 1'b1;
    end

    // Bit mask of the range within the current word
    always_comb begin
        lo_bit   = (word_idx_reg == lo_cell_reg[CELL_W-1:BIT_W]) ?
                   lo_cell_reg[BIT_W-1:0] : '0;
        hi_bit   = (word_idx_reg == hi_cell_reg[CELL_W-1:BIT_W]) ?
                   hi_cell_reg[BIT_W-1:0] : '1;
        upd_mask = ({WORD_W{1'b1}} << lo_bit) &
                   ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit));
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        start_next    = start_reg;
        count_next    = count_reg;
        run_next      = run_reg;
        word_idx_next = word_idx_reg;
        byte_idx_next = byte_idx_reg;
        lo_cell_next  = lo_cell_reg;
        hi_cell_next  = hi_cell_reg;
        set_next      = set_reg;
        res_addr_next = res_addr_reg;
        res_len_next  = res_len_reg;
        res_fail_next = res_fail_reg;
        m_tvalid_next = m_tvalid_reg;
        m_addr_next   = m_addr_reg;
        m_len_next    = m_len_reg;
        m_status_next = m_status_reg;
        ram_wr_en     = 1'b0;
        ram_wr_data   = '0;
        ram_rd_en     = 1'b0;

        // Drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                ram_wr_en = 1'b1;
                if (word_idx_reg == WORD_IDX_W'(WORDS - 1)) begin
                    word_idx_next = '0;
                    state_next    = S_IDLE;
                end else begin
                    word_idx_next = word_idx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    start_next = s_tdata[ADDR_W-1:0];
                    count_next = s_tdata[ADDR_W+CELL_W-1:ADDR_W];
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                if (op_reg == OP_ALLOC) begin
                    if (count_reg == '0) begin
                        res_addr_next = '0;
                        res_len_next  = '0;
                        res_fail_next = STATUS_NO_SPACE;
                        state_next    = S_RESP;
                    end else begin
                        run_next      = '0;
                        word_idx_next = '0;
                        state_next    = S_FETCH;
                    end
                end else begin
                    res_addr_next = start_reg;
                    res_len_next  = count_reg;
                    res_fail_next = STATUS_OK;
                    if (free_valid) begin
                        lo_cell_next  = free_lo_abs - CELL_W'(POOL_BASE);
                        hi_cell_next  = free_hi_abs - CELL_W'(POOL_BASE);
                        set_next      = 1'b0;
                        word_idx_next = free_lo_abs[CELL_W-1:BIT_W]
                                        - WORD_IDX_W'(POOL_BASE / WORD_W);
                        state_next    = S_UPD_RD;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_FETCH: begin
                ram_rd_en  = 1'b1;
                state_next = S_EXAM;
            end
            S_EXAM: begin
                if (ram_rd_data == '0 && word_fit) begin
                    // Run completes inside an all-free word
                    lo_cell_next  = hit_lo;
                    hi_cell_next  = hit_end;
                    set_next      = 1'b1;
                    res_addr_next = hit_lo + ADDR_W'(POOL_BASE);
                    res_len_next  = count_reg;
                    res_fail_next = STATUS_OK;
                    word_idx_next = hit_lo[CELL_W-1:BIT_W];
                    state_next    = S_UPD_RD;
                end else if (ram_rd_data == '0 || ram_rd_data == '1) begin
                    run_next = (ram_rd_data == '0) ? word_run_sum[CELL_W-1:0] : '0;
                    if (word_idx_reg == WORD_IDX_W'(WORDS - 1)) begin
                        res_addr_next = '0;
                        res_len_next  = '0;
                        res_fail_next = STATUS_NO_SPACE;
                        state_next    = S_RESP;
                    end else begin
                        word_idx_next = word_idx_reg + 1'b1;
                        state_next    = S_FETCH;
                    end
                end else begin
                    byte_idx_next = '0;
                    state_next    = S_BYTE;
                end
            end
            S_BYTE: begin
                if (byte_hit) begin
                    lo_cell_next  = hit_lo;
                    hi_cell_next  = hit_end;
                    set_next      = 1'b1;
                    res_addr_next = hit_lo + ADDR_W'(POOL_BASE);
                    res_len_next  = count_reg;
                    res_fail_next = STATUS_OK;
                    word_idx_next = hit_lo[CELL_W-1:BIT_W];
                    state_next    = S_UPD_RD;
                end else begin
                    run_next = byte_run;
                    if (byte_idx_reg != BYTE_IDX_W'(BYTES_PER_WORD - 1)) begin
                        byte_idx_next = byte_idx_reg + 1'b1;
                    end else if (word_idx_reg == WORD_IDX_W'(WORDS - 1)) begin
                        res_addr_next = '0;
                        res_len_next  = '0;
                        res_fail_next = STATUS_NO_SPACE;
                        state_next    = S_RESP;
                    end else begin
                        word_idx_next = word_idx_reg + 1'b1;
                        state_next    = S_FETCH;
                    end
                end
            end
            S_UPD_RD: begin
                ram_rd_en  = 1'b1;
                state_next = S_UPD_WR;
            end
            S_UPD_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = set_reg ? (ram_rd_data | upd_mask) : (ram_rd_data & ~upd_mask);
                if (word_idx_reg == hi_cell_reg[CELL_W-1:BIT_W]) begin
                    state_next = S_RESP;
                end else begin
                    word_idx_next = word_idx_reg + 1'b1;
                    state_next    = S_UPD_RD;
                end
            end
            S_RESP: begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_len_next    = res_len_reg;
                    m_status_next = res_fail_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            word_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            word_idx_reg <= word_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        start_reg    <= start_next;
        count_reg    <= count_next;
        run_reg      <= run_next;
        byte_idx_reg <= byte_idx_next;
        lo_cell_reg  <= lo_cell_next;
        hi_cell_reg  <= hi_cell_next;
        set_reg      <= set_next;
        res_addr_reg <= res_addr_next;
        res_len_reg  <= res_len_next;
        res_fail_reg <= res_fail_next;
        m_addr_reg   <= m_addr_next;
        m_len_reg    <= m_len_next;
        m_status_reg <= m_status_next;
    end

    // Ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(TDATA_W - ADDR_W - CELL_W)'(0), m_len_reg, m_addr_reg};
    assign m_tuser  = m_status_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `FFCA_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> state_reg == S_CLEAR,
        "reset did not start the clearing pass")
    `FFCA_ASSERT(a_accept_leaves_idle, aclk, aresetn,
        (s_tvalid && s_tready) |=> state_reg != S_IDLE,
        "accepted transaction did not start work")
    `FFCA_ASSERT(a_run_below_count, aclk, aresetn,
        (state_reg == S_EXAM || state_reg == S_BYTE) |-> run_reg < count_reg,
        "free run reached the request length without a hit")
    `FFCA_ASSERT(a_clear_only_on_free, aclk, aresetn,
        (state_reg == S_UPD_WR && !set_reg) |-> op_reg == OP_FREE,
        "marks cleared outside a free request")
    `FFCA_ASSERT(a_result_from_resp, aclk, aresetn,
        $rose(m_tvalid_reg) |-> $past(state_reg == S_RESP),
        "result presented without completing a request")
    `FFCA_ASSERT(a_mask_nonempty, aclk, aresetn,
        state_reg == S_UPD_WR |-> upd_mask != '0,
        "mark update touched a word outside its range")

endmodule
